// ===== rtl/core/lru_handle_cache_with_idle_evict_assert.svh =====
// Assertion macros used by the cache's port checker file.
`ifndef LRU_HANDLE_CACHE_WITH_IDLE_EVICT_ASSERT_SVH
`define LRU_HANDLE_CACHE_WITH_IDLE_EVICT_ASSERT_SVH

// Clocked check that is switched off while reset is applied.
`define LRUC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lruc check failed");

// Clocked check that also holds during reset.
`define LRUC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lruc check failed during or after reset");

`endif

// ===== rtl/core/lruc_pkg.sv =====
// Types and constants shared by the handle cache modules.
`default_nettype none
package lruc_pkg;
	localparam int TICK_W = 64;
	localparam int SLOT_INDEX_W = 3;
	localparam int MASK_W = 8;
	localparam logic [TICK_W-1:0] MAX_IDLE_RESET = 64'd5000000;
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_SWEEP = 1'b1;

	typedef struct packed {
		logic [32:0] kind_size;
		logic [63:0] color;
		logic [63:0] albedo;
		logic [63:0] normal;
		logic [63:0] outbuf;
	} key_t;

	typedef struct packed {
		logic match;
		logic exceeds;
		logic [TICK_W-1:0] age;
	} eval_t;
endpackage
`default_nettype wire

// ===== rtl/core/lruc_slot_eval.sv =====
// Shared slot evaluator: key compare, wrapped age and age compare against a limit.
`default_nettype none
module lruc_slot_eval
	import lruc_pkg::*;
(
	input  wire logic              slot_valid,
	input  wire key_t              slot_key,
	input  wire logic [TICK_W-1:0] slot_last_use,
	input  wire key_t              item_key,
	input  wire logic [TICK_W-1:0] item_tick,
	input  wire logic [TICK_W-1:0] limit,
	output eval_t                  eval
);
	logic [TICK_W-1:0] age;

	assign age = item_tick - slot_last_use;
	assign eval.age = age;
	assign eval.match = slot_valid && (slot_key == item_key);
	assign eval.exceeds = age > limit;
endmodule
`default_nettype wire

// ===== rtl/core/lru_handle_cache_with_idle_evict.sv =====
// Top level of the fully associative handle cache with idle eviction.
//  channel | direction | handshake            | word
//  in      | in        | in_valid / in_ready   | lookup key, tick, build flag, operation
//  out     | out       | out_valid / out_ready | success, hit, slot, release flag, mask
//  cfg     | in        | cfg_wr_en             | idle limit in ticks
// A new word is accepted only once the previous one is done: the idle state takes the word in,
// one evaluator walks the slots one per cycle, then the done state applies the update.
// A lookup with an absent colour or output address skips the walk and goes straight to the done state.
// Reset clears the valid bits and the last-use times and restores the default idle limit;
// there is no clearing pass.
// A held result stalls only the final update cycle.
`default_nettype none
module lru_handle_cache_with_idle_evict
	import lruc_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [TICK_W-1:0]       cfg_wr_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    operation,
	input  wire logic                    job_kind,
	input  wire logic [15:0]             image_width,
	input  wire logic [15:0]             image_height,
	input  wire logic [63:0]             color_addr,
	input  wire logic [63:0]             albedo_addr,
	input  wire logic [63:0]             normal_addr,
	input  wire logic [63:0]             output_addr,
	input  wire logic [TICK_W-1:0]       now_tick,
	input  wire logic                    build_ok,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         success,
	output logic                         hit,
	output logic [SLOT_INDEX_W-1:0]      slot_index,
	output logic                         victim_released,
	output logic [MASK_W-1:0]            released_mask
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [TICK_W-1:0] max_idle_q;

	logic [SLOTS-1:0]  valid_q;
	key_t              key_q [SLOTS];
	logic [TICK_W-1:0] last_use_q [SLOTS];

	logic              op_q;
	logic              absent_q;
	key_t              item_key_q;
	logic [TICK_W-1:0] item_tick_q;
	logic              build_q;
	logic [IW-1:0]     cnt_q;
	logic              found_q;
	logic [IW-1:0]     hit_idx_q;
	logic [IW-1:0]     victim_q;
	logic [TICK_W-1:0] best_q;
	logic [MASK_W-1:0] mask_q;

	logic                    out_valid_q;
	logic                    success_q;
	logic                    hit_q;
	logic [SLOT_INDEX_W-1:0] slot_index_q;
	logic                    released_q;
	logic [MASK_W-1:0]       out_mask_q;

	key_t              in_key;
	logic              in_fire;
	logic              done_fire;
	logic              scan_evict;
	logic [TICK_W-1:0] limit;
	eval_t             ev;

	assign in_key = '{kind_size: {job_kind, image_width, image_height},
		color: color_addr, albedo: albedo_addr, normal: normal_addr, outbuf: output_addr};
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign limit = (op_q == OP_SWEEP) ? max_idle_q : best_q;
	assign scan_evict = (state_q == ST_SCAN) && (op_q == OP_SWEEP) && valid_q[cnt_q]
		&& ev.exceeds;

	lruc_slot_eval u_eval (
		.slot_valid    (valid_q[cnt_q]),
		.slot_key      (key_q[cnt_q]),
		.slot_last_use (last_use_q[cnt_q]),
		.item_key      (item_key_q),
		.item_tick     (item_tick_q),
		.limit         (limit),
		.eval          (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_idle_q <= MAX_IDLE_RESET;
		end else if (cfg_wr_en) begin
			max_idle_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						if (operation == OP_LOOKUP && (color_addr == '0 || output_addr == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= operation;
			absent_q <= (operation == OP_LOOKUP) && (color_addr == '0 || output_addr == '0);
			item_key_q <= in_key;
			item_tick_q <= now_tick;
			build_q <= build_ok;
			found_q <= 1'b0;
			hit_idx_q <= '0;
			victim_q <= '0;
			best_q <= '0;
			mask_q <= '0;
		end else if (state_q == ST_SCAN) begin
			if (op_q == OP_SWEEP) begin
				if (scan_evict && int'(cnt_q) < MASK_W) begin
					mask_q[3'(cnt_q)] <= 1'b1;
				end
			end else begin
				if (ev.match && !found_q) begin
					found_q <= 1'b1;
					hit_idx_q <= cnt_q;
				end
				if (ev.exceeds) begin
					best_q <= ev.age;
					victim_q <= cnt_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				last_use_q[i] <= '0;
			end
		end else if (scan_evict) begin
			valid_q[cnt_q] <= 1'b0;
		end else if (done_fire && op_q == OP_LOOKUP && !absent_q) begin
			if (found_q) begin
				last_use_q[hit_idx_q] <= item_tick_q;
			end else begin
				valid_q[victim_q] <= build_q;
				if (build_q) begin
					last_use_q[victim_q] <= item_tick_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_evict) begin
			key_q[cnt_q] <= '0;
		end else if (done_fire && op_q == OP_LOOKUP && !absent_q && !found_q && build_q) begin
			key_q[victim_q] <= item_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			success_q <= 1'b0;
			hit_q <= 1'b0;
			slot_index_q <= '0;
			released_q <= 1'b0;
			out_mask_q <= '0;
			if (op_q == OP_SWEEP) begin
				out_mask_q <= mask_q;
			end else if (!absent_q) begin
				if (found_q) begin
					success_q <= 1'b1;
					hit_q <= 1'b1;
					slot_index_q <= SLOT_INDEX_W'(hit_idx_q);
				end else begin
					success_q <= build_q;
					slot_index_q <= SLOT_INDEX_W'(victim_q);
					released_q <= valid_q[victim_q];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign success = success_q;
	assign hit = hit_q;
	assign slot_index = slot_index_q;
	assign victim_released = released_q;
	assign released_mask = out_mask_q;
endmodule
`default_nettype wire

// ===== rtl/core/lruc_port_checker.sv =====
// Port-level checks for the handle cache and their binding to the top level.
`default_nettype none
`include "lru_handle_cache_with_idle_evict_assert.svh"
module lruc_port_checker
	import lruc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              success,
	input wire logic              hit,
	input wire logic              victim_released,
	input wire logic [MASK_W-1:0] released_mask
);
	// A word is worked on alone, so the block is busy in the cycle after acceptance.
	`LRUC_ASSERT(busy_after_accept, in_valid && in_ready |=> !in_ready)
	`LRUC_ASSERT(out_held, out_valid && !out_ready |=> out_valid)
	`LRUC_ASSERT(hit_is_success, out_valid && hit |-> success && !victim_released)
	`LRUC_ASSERT_ALWAYS(sweep_word_clean,
		out_valid && released_mask != '0 |-> !success && !hit && !victim_released)
endmodule

bind lru_handle_cache_with_idle_evict lruc_port_checker u_port_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.success         (success),
	.hit             (hit),
	.victim_released (victim_released),
	.released_mask   (released_mask)
);
`default_nettype wire
